// ----- rtl/soft_timer_bank_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SOFT_TIMER_BANK_DEFINES_SVH
`define SOFT_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("soft_timer_bank check failed");

// Next-cycle implication, disabled during reset.
`define STB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("soft_timer_bank check failed");

`endif

// ----- rtl/stb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

  localparam int STB_TIMER_COUNT = 8;
  localparam int STB_PADDR_W     = 3;

  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_RUN      = 3'd1;
  localparam logic [2:0] KIND_LOAD     = 3'd2;
  localparam logic [2:0] KIND_LOAD_RUN = 3'd3;
  localparam logic [2:0] KIND_STOP     = 3'd4;
  localparam logic [2:0] KIND_QUERY    = 3'd5;

  localparam logic RES_EXPIRY = 1'b0;
  localparam logic RES_QUERY  = 1'b1;

  localparam logic REG_EVENT_ENABLE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [31:0] count;
    logic        run;
  } cell_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        match;
    logic [31:0] load;
    logic        en_bit;
  } head_op_t;

  typedef struct packed {
    cell_t slot;
    logic  evt;
    logic  query_hit;
  } head_res_t;

endpackage

`default_nettype wire

// ----- rtl/stb_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stb_cell (
  input  wire           clk,
  input  wire           rst,
  input  wire           shift,
  input  stb_pkg::cell_t d,
  output stb_pkg::cell_t q
);
  import stb_pkg::*;

  cell_t held;

  // Take the neighbor's timer on each shift, hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (shift) begin
      held <= d;
    end
  end

  assign q = held;

endmodule

`default_nettype wire

// ----- rtl/stb_proc.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stb_proc (
  input  stb_pkg::cell_t    head,
  input  stb_pkg::head_op_t op,
  output stb_pkg::head_res_t res
);
  import stb_pkg::*;

  logic nonzero;

  assign nonzero = (head.count != 32'd0);

  always_comb begin
    res           = '0;
    res.slot      = head;
    unique case (op.kind)
      KIND_TICK: begin
        if (head.run && nonzero) begin
          res.slot.count = head.count - 32'd1;
          res.evt        = (head.count == 32'd1) && op.en_bit;
        end
      end
      KIND_RUN: begin
        if (op.match) res.slot.run = 1'b1;
      end
      KIND_LOAD: begin
        if (op.match) res.slot.count = op.load;
      end
      KIND_LOAD_RUN: begin
        if (op.match) begin
          res.slot.count = op.load;
          res.slot.run   = 1'b1;
        end
      end
      KIND_STOP: begin
        if (op.match) res.slot.run = 1'b0;
      end
      KIND_QUERY: begin
        // Stop a timer found running at zero.
        if (op.match && head.run && !nonzero) begin
          res.slot.run  = 1'b0;
          res.query_hit = 1'b1;
        end
      end
      default: begin
        res.slot = head;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/soft_timer_bank.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bank of TIMER_COUNT 32-bit down-counting timers. The timers sit in a ring
// of cells that rotates by one place per cycle, except while an expiry stalls
// on a full output; a single update unit at the head of the ring applies the
// current command to whichever timer passes it. Every input word (tick, run,
// load, load-and-run, stop, timeout query) is accepted, walked once around the
// ring and then flushed; the walk stalls while the output register is full and
// another result is waiting. in_ready is high only between words.
// A tick emits one expiry word per enabled timer that reaches zero, in rising
// index order, with last on the final one; a query always emits one word.
// The event enable register sits at byte address 0 of the APB-style port.
module soft_timer_bank #(
  parameter int TIMER_COUNT = stb_pkg::STB_TIMER_COUNT
) (
  input  wire                             clk,
  input  wire                             rst,
  // input channel
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [2:0]                      kind,
  input  wire  [7:0]                      timer_index,
  input  wire  [31:0]                     load_value,
  // result channel
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic                            result_kind,
  output logic [7:0]                      result_timer,
  output logic                            timed_out,
  output logic                            last,
  // configuration port
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [stb_pkg::STB_PADDR_W-1:0] paddr,
  input  wire  [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import stb_pkg::*;

  localparam int STEP_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TIMER_COUNT - 1);

  // Configuration: one register, the per-timer event enables.
  logic [7:0] event_enable;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_enable <= 8'd0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_EVENT_ENABLE)) begin
      event_enable <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_EVENT_ENABLE) prdata = {24'd0, event_enable};
  end

  // Sequencer and latched command.
  state_t            state, state_next;
  logic [STEP_W-1:0] step;
  logic [7:0]        step_ext;
  logic [2:0]        op_kind;
  logic [7:0]        op_idx;
  logic [31:0]       op_load;

  // One pending result: it goes out only once we know whether it is the last.
  logic              pend_valid;
  logic              pend_kind;
  logic [7:0]        pend_timer;
  logic              pend_tout;

  logic              can_push;
  logic              push;
  logic              push_last;
  logic              shift;

  head_op_t          hop;
  head_res_t         hres;
  cell_t             ring_q [TIMER_COUNT];

  assign step_ext = {{(8 - STEP_W){1'b0}}, step};
  assign can_push = !out_valid || out_ready;

  // Ring of timer cells: each cell takes from its upper neighbor, the top cell
  // takes the updated head, so a full rotation restores the original order.
  for (genvar k = 0; k < TIMER_COUNT; k++) begin : g_ring
    cell_t d_in;
    if (k == TIMER_COUNT - 1) begin : g_top
      assign d_in = hres.slot;
    end else begin : g_mid
      assign d_in = ring_q[k + 1];
    end
    stb_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d_in),
      .q     (ring_q[k])
    );
  end

  // Head update: the timer at ring position 0 is timer number step.
  always_comb begin
    hop.kind   = op_kind;
    hop.match  = (op_idx == step_ext);
    hop.load   = op_load;
    // Only the first eight timers have an enable bit.
    hop.en_bit = (step_ext < 8'd8) ? event_enable[step_ext[2:0]] : 1'b0;
  end

  stb_proc u_proc (
    .head (ring_q[0]),
    .op   (hop),
    .res  (hres)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_WALK;
      ST_WALK:  if (shift && (step == STEP_LAST)) state_next = ST_FLUSH;
      ST_FLUSH: if (!pend_valid || can_push) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    shift     = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_WALK: begin
        // A new event displaces the pending one; stall if it cannot leave.
        shift = !(hres.evt && pend_valid && !can_push);
        push  = hres.evt && pend_valid && can_push;
      end
      ST_FLUSH: begin
        push      = pend_valid && can_push;
        push_last = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_WALK && shift) begin
        step <= (step == STEP_LAST) ? '0 : step + STEP_W'(1);
      end
    end
  end

  // Latch the command word.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_kind <= kind;
      op_idx  <= timer_index;
      op_load <= load_value;
    end
  end

  // Pending result.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            // A query always answers, false unless the walk finds a hit.
            pend_valid <= (kind == KIND_QUERY);
            pend_kind  <= RES_QUERY;
            pend_timer <= timer_index;
            pend_tout  <= 1'b0;
          end
        end
        ST_WALK: begin
          if (shift && hres.evt) begin
            pend_valid <= 1'b1;
            pend_kind  <= RES_EXPIRY;
            pend_timer <= step_ext;
            pend_tout  <= 1'b0;
          end
          if (shift && hres.query_hit) pend_tout <= 1'b1;
        end
        ST_FLUSH: begin
          if (push) pend_valid <= 1'b0;
        end
        default: begin
          pend_valid <= 1'b0;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result_kind  <= pend_kind;
      result_timer <= pend_timer;
      timed_out    <= pend_tout;
      last         <= push_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "soft_timer_bank_defines.svh"

module stb_checker #(
  parameter int TIMER_COUNT = stb_pkg::STB_TIMER_COUNT
) (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       result_kind,
  input wire [7:0] result_timer,
  input wire       timed_out,
  input wire       last
);
  import stb_pkg::*;

  logic expiry_ok;

  assign expiry_ok = !timed_out && (result_timer < 8'(TIMER_COUNT));

  // A result word stays offered until taken.
  `STB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // One word at a time: accepting a word closes the input.
  `STB_ASSERT_NEXT(a_in_busy, clk, rst, in_valid && in_ready, !in_ready)

  // A query answer is the only result of its word.
  `STB_ASSERT_NOW(a_query_last, clk, rst, out_valid && (result_kind == RES_QUERY), last)

  // Expiry words carry no timeout flag and name a real timer.
  `STB_ASSERT_NOW(a_expiry_sane, clk, rst, out_valid && (result_kind == RES_EXPIRY), expiry_ok)

endmodule

bind soft_timer_bank stb_checker #(.TIMER_COUNT(TIMER_COUNT)) u_stb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_kind  (result_kind),
  .result_timer (result_timer),
  .timed_out    (timed_out),
  .last         (last)
);

`default_nettype wire

// ----- tb/tb_soft_timer_bank.sv -----
`timescale 1ns / 1ps

module tb_soft_timer_bank;
  import stb_pkg::*;

  localparam int NUM_TIMERS   = STB_TIMER_COUNT;
  // An accept, one pass around the ring and a flush per word, with margin.
  localparam int DRAIN_CYCLES = 3 * (NUM_TIMERS + 2);
  localparam int LIMIT_CYCLES = 400_000;

  // Kinds that the block must ignore.
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  // Register i sits at byte address 4*i; the next slot holds no register.
  localparam logic [STB_PADDR_W-1:0] ADDR_EVENT_ENABLE = STB_PADDR_W'(4 * REG_EVENT_ENABLE);
  localparam logic [STB_PADDR_W-1:0] ADDR_SPARE        = STB_PADDR_W'(4 * (REG_EVENT_ENABLE + 1));

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  idx;
    logic [31:0] load;
  } timer_word_t;

  typedef struct packed {
    logic       rkind;
    logic [7:0] rtimer;
    logic       tout;
    logic       rlast;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        in_valid = 1'b0;
  wire         in_ready;
  logic [2:0]  kind = KIND_TICK;
  logic [7:0]  timer_index = '0;
  logic [31:0] load_value = '0;

  wire         out_valid;
  logic        out_ready = 1'b0;
  wire         result_kind;
  wire  [7:0]  result_timer;
  wire         timed_out;
  wire         last;

  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [STB_PADDR_W-1:0] paddr = '0;
  logic [31:0]            pwdata = '0;
  wire  [31:0]            prdata;
  wire                    pready;

  soft_timer_bank dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .timer_index  (timer_index),
    .load_value   (load_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .result_timer (result_timer),
    .timed_out    (timed_out),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Words waiting for the driver, and results the bank still owes us.
  timer_word_t   word_queue[$];
  timer_result_t expected_results[$];

  // Shadow of the bank: per-timer count and running flag, plus the enable register.
  logic [31:0] timer_ticks[NUM_TIMERS];
  logic        timer_running[NUM_TIMERS];
  logic [7:0]  enable_mirror;

  int send_idle_pct = 9;
  int recv_idle_pct = 86;

  int mismatch_count  = 0;
  int words_accepted  = 0;
  int ticks_accepted  = 0;
  int results_checked = 0;
  int expiry_seen     = 0;
  int timeouts_seen   = 0;
  int cycle_count     = 0;

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_ticks[i]   = '0;
      timer_running[i] = 1'b0;
    end
    enable_mirror = '0;
  end

  function automatic void report_mismatch(string what, longint expv, longint got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %0d at cycle %0d: %s expected %0h got %0h",
               mismatch_count, cycle_count, what, expv, got);
    end
  endfunction

  // Apply one accepted word to the shadow bank and queue the results it owes.
  function automatic void advance_timers(timer_word_t w);
    logic                  in_range;
    logic [NUM_TIMERS-1:0] fired;
    int                    final_hit;
    logic                  hit;
    in_range  = w.idx < NUM_TIMERS;
    fired     = '0;
    final_hit = -1;
    hit       = 1'b0;
    case (w.kind)
      KIND_TICK: begin
        // Walk in index order; only running timers with a count left move.
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (timer_running[i] && timer_ticks[i] != 0) begin
            timer_ticks[i] = timer_ticks[i] - 1;
            if (timer_ticks[i] == 0 && i < 8 && enable_mirror[i]) begin
              fired[i]  = 1'b1;
              final_hit = i;
            end
          end
        end
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (fired[i]) begin
            expected_results.push_back('{RES_EXPIRY, 8'(i), 1'b0, i == final_hit});
          end
        end
      end
      KIND_RUN: begin
        if (in_range) timer_running[w.idx] = 1'b1;
      end
      KIND_LOAD: begin
        // Store the count, leave the running flag alone.
        if (in_range) timer_ticks[w.idx] = w.load;
      end
      KIND_LOAD_RUN: begin
        if (in_range) begin
          timer_ticks[w.idx]   = w.load;
          timer_running[w.idx] = 1'b1;
        end
      end
      KIND_STOP: begin
        if (in_range) timer_running[w.idx] = 1'b0;
      end
      KIND_QUERY: begin
        // Running at zero counts as a timeout, and the query stops the timer.
        if (in_range && timer_running[w.idx] && timer_ticks[w.idx] == 0) begin
          timer_running[w.idx] = 1'b0;
          hit = 1'b1;
        end
        expected_results.push_back('{RES_QUERY, w.idx, hit, 1'b1});
      end
      default: begin
      end
    endcase
  endfunction

  // Driver: retire the word at the handshake, then offer the next or idle.
  always @(posedge clk) begin
    timer_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_timers('{kind, timer_index, load_value});
        words_accepted++;
        if (kind == KIND_TICK) ticks_accepted++;
      end
      // Hold the payload while a word waits for ready.
      if (!in_valid || in_ready) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          w = word_queue.pop_front();
          in_valid    <= 1'b1;
          kind        <= w.kind;
          timer_index <= w.idx;
          load_value  <= w.load;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: match each result word against the oldest expectation.
  always @(posedge clk) begin
    timer_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected, timer", 0, result_timer);
        end else begin
          e = expected_results.pop_front();
          if (result_kind !== e.rkind) report_mismatch("result_kind", e.rkind, result_kind);
          if (result_timer !== e.rtimer) report_mismatch("result_timer", e.rtimer, result_timer);
          if (timed_out !== e.tout) report_mismatch("timed_out", e.tout, timed_out);
          if (last !== e.rlast) report_mismatch("last", e.rlast, last);
          if (e.rkind == RES_EXPIRY) expiry_seen++;
          if (e.rkind == RES_QUERY && e.tout) timeouts_seen++;
        end
      end
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_word(logic [2:0] k, logic [7:0] idx, logic [31:0] val);
    word_queue.push_back('{k, idx, val});
  endtask

  // Wait until every word is taken and every owed result has arrived.
  // Sample at the falling edge so the driver's bookkeeping has settled.
  task automatic wait_idle();
    @(negedge clk);
    while (word_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Quiet point for register access: also cover words that owe no result.
  task automatic settle();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup, access, complete on pready.
  task automatic apb_access(logic wr, logic [STB_PADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      if (addr == ADDR_EVENT_ENABLE) enable_mirror = data[7:0];
    end else if (prdata !== {24'b0, enable_mirror}) begin
      report_mismatch("prdata", {24'b0, enable_mirror}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the enable mask with junk in the upper bits, then read it back.
  task automatic set_event_enable(logic [7:0] mask);
    apb_access(1'b1, ADDR_EVENT_ENABLE, {24'($urandom), mask});
    apb_access(1'b0, ADDR_EVENT_ENABLE, '0);
  endtask

  // Mostly in-range traffic with short counts so timers expire often;
  // a few far indexes, huge counts and spare kinds mixed in as noise.
  task automatic add_random_words(int count);
    int          pick;
    logic [2:0]  k;
    logic [7:0]  idx;
    logic [31:0] val;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 38)      k = KIND_TICK;
      else if (pick < 53) k = KIND_LOAD_RUN;
      else if (pick < 61) k = KIND_LOAD;
      else if (pick < 68) k = KIND_RUN;
      else if (pick < 74) k = KIND_STOP;
      else if (pick < 94) k = KIND_QUERY;
      else if (pick < 97) k = KIND_SPARE_6;
      else                k = KIND_SPARE_7;
      if ($urandom_range(99) < 8) idx = 8'($urandom_range(255));
      else                        idx = 8'($urandom_range(NUM_TIMERS - 1));
      if ($urandom_range(9) == 0) val = $urandom();
      else                        val = 32'($urandom_range(4));
      push_word(k, idx, val);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Enable mask still at reset: an expiry must stay silent, the query still sees it.
    push_word(KIND_LOAD_RUN, 8'd0, 32'd1);
    push_word(KIND_TICK, 8'd0, 32'd0);
    push_word(KIND_QUERY, 8'd0, 32'd0);
    push_word(KIND_QUERY, 8'd0, 32'd0);
    settle();
    set_event_enable(8'hFF);

    // Load while stopped keeps the timer idle; then run it and reload to zero.
    push_word(KIND_LOAD, 8'd2, 32'hFFFF_FFFF);
    push_word(KIND_TICK, 8'd0, 32'd0);
    push_word(KIND_RUN, 8'd2, 32'd0);
    push_word(KIND_TICK, 8'd0, 32'd0);
    push_word(KIND_LOAD, 8'd2, 32'd0);
    push_word(KIND_QUERY, 8'd2, 32'd0);
    // Three timers expiring on one tick: rising index, last on the final one.
    push_word(KIND_LOAD_RUN, 8'd1, 32'd2);
    push_word(KIND_LOAD_RUN, 8'd3, 32'd2);
    push_word(KIND_LOAD_RUN, 8'd7, 32'd2);
    push_word(KIND_TICK, 8'd0, 32'd0);
    push_word(KIND_TICK, 8'd0, 32'd0);
    // Stopped timer freezes and never reports a timeout.
    push_word(KIND_LOAD_RUN, 8'd5, 32'd3);
    push_word(KIND_STOP, 8'd5, 32'd0);
    push_word(KIND_TICK, 8'd0, 32'd0);
    push_word(KIND_QUERY, 8'd5, 32'd0);
    // Out-of-range indexes and spare kinds are dropped; queries still answer.
    push_word(KIND_LOAD_RUN, 8'd8, 32'd1);
    push_word(KIND_QUERY, 8'd8, 32'd0);
    push_word(KIND_QUERY, 8'd255, 32'd0);
    push_word(KIND_SPARE_6, 8'd0, 32'd1);
    push_word(KIND_SPARE_7, 8'd255, 32'hFFFF_FFFF);
    push_word(KIND_STOP, 8'd255, 32'd0);
    push_word(KIND_TICK, 8'd0, 32'd0);
    settle();

    // Slow consumer, all events enabled.
    send_idle_pct = 9;
    recv_idle_pct = 86;
    add_random_words(49);
    settle();

    // A write to the empty slot must not touch the mask; read back proves it.
    apb_access(1'b1, ADDR_SPARE, 32'hFFFF_FFFF);
    apb_access(1'b0, ADDR_EVENT_ENABLE, '0);
    set_event_enable(8'($urandom_range(254, 1)));

    // Slow producer; drain completely halfway through before resuming.
    send_idle_pct = 86;
    recv_idle_pct = 9;
    add_random_words(40);
    wait_idle();
    add_random_words(35);
    settle();

    // Back to back, fresh mask.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_event_enable(8'($urandom));
    add_random_words(60);
    settle();

    // All events masked: only query answers may come out.
    set_event_enable(8'h00);
    add_random_words(20);
    settle();

    $display("covered %0d words (%0d ticks) over five enable masks and three idle mixes;",
             words_accepted, ticks_accepted);
    $display("checked %0d result words: %0d expiry events, %0d query timeouts",
             results_checked, expiry_seen, timeouts_seen);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- soft_timer_bank.f -----
+incdir+rtl
rtl/stb_pkg.sv
rtl/stb_cell.sv
rtl/stb_proc.sv
rtl/soft_timer_bank.sv
rtl/stb_checker.sv
tb/tb_soft_timer_bank.sv
